// ===== rtl/ncdf_pkg.sv =====
`timescale 1ns / 1ps

package ncdf_pkg;

    // pipeline depth from input beat to output register
    localparam int NSTG     = 33;
    localparam int TAYLOR_N = 8;
    localparam int HORNER_N = 5;
    localparam int DIV_N    = 17;

    localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;
    localparam logic [15:0] P_Q16         = 16'd21469;
    localparam logic [16:0] LOG2E_Q16     = 17'd94548;
    localparam logic [29:0] LN2_Q30       = 30'd744261118;
    localparam logic [30:0] ONE_Q30       = 31'h4000_0000;

    localparam logic signed [24:0] A5_Q20 = 25'sd1112964;

    // horner addends a4, a3, a2, a1, then none for the last product
    localparam logic signed [24:0] HCOEF [HORNER_N] =
        '{-25'sd1523740, 25'sd1490460, -25'sd298316, 25'sd267208, 25'sd0};

    // taylor step j divides by n = 8 - j
    localparam logic [3:0]  DIVN  [TAYLOR_N] =
        '{4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1};
    localparam logic        POW2  [TAYLOR_N] =
        '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    localparam logic [1:0]  SHAMT [TAYLOR_N] =
        '{2'd3, 2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd1, 2'd0};
    // floor(2^33 / n) for the non power of two divisors
    localparam logic [31:0] RECIP [TAYLOR_N] =
        '{32'd0, 32'd1227133513, 32'd1431655765, 32'd1717986918,
          32'd0, 32'd2863311530, 32'd0, 32'd0};

endpackage

// ===== rtl/normal_cdf_erf_approx.sv =====
`timescale 1ns / 1ps

// standard normal cdf of a q4.12 sample, returned as unsigned q0.16 and
// saturated at 65535, built on the 7.1.26 erf approximation. the block is a
// 33 stage pipeline: one beat is taken every cycle when the output side
// keeps tready high. the depth is set by the reciprocal t = 1/(1+p*z), a
// restoring divider that resolves one quotient bit per stage (17 stages),
// followed by five horner multiply and round stage pairs; the exp(-z^2)
// path (eight taylor steps of three stages each) runs beside it. a stall
// on the output freezes the whole pipeline, so no beat is lost or repeated,
// and the input stays ready whenever the output register is empty or being
// drained. there is no configuration and no state between beats.

module normal_cdf_erf_approx
    import ncdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_x
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] probability
);

    logic              adv;
    logic [NSTG:1]     vld_reg;
    logic              neg_reg [1:NSTG-1];

    // front end: magnitude, z, p*z, z^2, d, u, g
    logic [16:0] a1_reg, a1_next;
    logic [33:0] z_prod;
    logic [18:0] z2_reg, z2_next;
    logic [34:0] pz_prod;
    logic [37:0] w_prod;
    logic [16:0] pz3_reg, pz3_next;
    logic [21:0] w3_reg, w3_next;
    logic [17:0] d4_reg, d4_next;
    logic [39:0] u_prod;
    logic [21:0] u4_reg, u4_next;
    logic [45:0] g_prod;
    logic [29:0] g5_reg, g5_next;
    logic [5:0]  k_reg [5:29];

    // taylor steps for 2^-f
    logic [60:0] tp_prod [TAYLOR_N];
    logic [61:0] tq_prod [TAYLOR_N];
    logic [33:0] tr_rem  [TAYLOR_N];
    logic [29:0] tp_reg  [TAYLOR_N];
    logic [29:0] tp_next [TAYLOR_N];
    logic [29:0] tga_reg [TAYLOR_N];
    logic [29:0] tq_reg  [TAYLOR_N];
    logic [29:0] tq_next [TAYLOR_N];
    logic [29:0] tpb_reg [TAYLOR_N];
    logic [29:0] tgb_reg [TAYLOR_N];
    logic [30:0] te_reg  [TAYLOR_N];
    logic [30:0] te_next [TAYLOR_N];
    logic [29:0] tgc_reg [TAYLOR_N];

    // restoring divider for t
    logic [19:0] dv_trial [DIV_N];
    logic [17:0] dv_d     [DIV_N];
    logic [18:0] dr_reg   [DIV_N];
    logic [18:0] dr_next  [DIV_N];
    logic [17:0] dd_reg   [DIV_N];
    logic [16:0] dq_reg   [DIV_N];
    logic [16:0] dq_next  [DIV_N];

    // horner polynomial
    logic signed [24:0] h_acc  [HORNER_N];
    logic [16:0]        h_t    [HORNER_N];
    logic [23:0]        h_mag  [HORNER_N];
    logic [40:0]        h_rnd  [HORNER_N];
    logic signed [24:0] h_val  [HORNER_N];
    logic [40:0]        hm_reg [HORNER_N];
    logic [40:0]        hm_next[HORNER_N];
    logic               hs_reg [HORNER_N];
    logic [16:0]        htm_reg[HORNER_N];
    logic signed [24:0] ha_reg [HORNER_N];
    logic signed [24:0] ha_next[HORNER_N];
    logic [16:0]        hta_reg[HORNER_N];

    // back end
    logic [30:0] ee30_reg, ee30_next;
    logic [30:0] ee31_reg;
    logic [23:0] poly;
    logic [54:0] pe32_reg, pe32_next;
    logic [54:0] h_sum;
    logic [16:0] h_clamp;
    logic [16:0] res;
    logic [15:0] out_reg, out_next;

    // whole pipeline advances unless a finished beat is held at the output
    assign adv      = !vld_reg[NSTG] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NSTG];
    assign m_tdata  = out_reg;

    always_comb
    begin
        // stage 1: |x|
        a1_next = s_tdata[15] ? (17'h10000 - {1'b0, s_tdata}) : {1'b0, s_tdata};
        // stage 2: z = |x| / sqrt(2) in q16
        z_prod  = 34'(a1_reg) * 34'(INV_SQRT2_Q16) + 34'd2048;
        z2_next = z_prod[30:12];
        // stage 3: p*z and z^2
        pz_prod  = 35'(z2_reg) * 35'(P_Q16) + 35'd32768;
        pz3_next = pz_prod[32:16];
        w_prod   = 38'(z2_reg) * 38'(z2_reg) + 38'd32768;
        w3_next  = w_prod[37:16];
        // stage 4: divisor and z^2*log2(e)
        d4_next = 18'h10000 + 18'(pz3_reg);
        u_prod  = 40'(w3_reg) * 40'(LOG2E_Q16) + 40'd32768;
        u4_next = u_prod[37:16];
        // stage 5: fraction times ln2
        g_prod  = 46'(u4_reg[15:0]) * 46'(LN2_Q30);
        g5_next = g_prod[45:16];

        // taylor: e = 1 - (e*g)/n, three stages per step
        for (int j = 0; j < TAYLOR_N; j++)
        begin
            tp_prod[j] = (j == 0) ? 61'(ONE_Q30) * 61'(g5_reg)
                                  : 61'(te_reg[(j == 0) ? 0 : j - 1]) *
                                    61'(tgc_reg[(j == 0) ? 0 : j - 1]);
            tp_next[j] = tp_prod[j][59:30];
            tq_prod[j] = 62'(tp_reg[j]) * 62'(RECIP[j]);
            tq_next[j] = POW2[j] ? (tp_reg[j] >> SHAMT[j]) : 30'(tq_prod[j][61:33]);
            // reciprocal estimate is at most one short
            tr_rem[j]  = 34'(tpb_reg[j]) - 34'(tq_reg[j]) * 34'(DIVN[j]);
            te_next[j] = ONE_Q30 - 31'(tq_reg[j] + 30'(tr_rem[j] >= 34'(DIVN[j])));
        end

        // divider: (2^32 + d/2) / d, one quotient bit per stage
        for (int i = 0; i < DIV_N; i++)
        begin
            dv_d[i]     = (i == 0) ? d4_reg : dd_reg[(i == 0) ? 0 : i - 1];
            dv_trial[i] = (i == 0) ? {19'd32768, dv_d[i][DIV_N - i]}
                                   : {dr_reg[(i == 0) ? 0 : i - 1],
                                      dv_d[i][DIV_N - i]};
            if (dv_trial[i] >= 20'(dv_d[i]))
            begin
                dr_next[i] = 19'(dv_trial[i] - 20'(dv_d[i]));
            end
            else
            begin
                dr_next[i] = dv_trial[i][18:0];
            end
            dq_next[i] = (i == 0) ? {16'd0, dv_trial[i] >= 20'(dv_d[i])}
                                  : {dq_reg[(i == 0) ? 0 : i - 1][15:0],
                                     dv_trial[i] >= 20'(dv_d[i])};
        end

        // horner: multiply stage then round and add stage
        for (int h = 0; h < HORNER_N; h++)
        begin
            h_acc[h]  = (h == 0) ? A5_Q20 : ha_reg[(h == 0) ? 0 : h - 1];
            h_t[h]    = (h == 0) ? dq_reg[DIV_N - 1] : hta_reg[(h == 0) ? 0 : h - 1];
            h_mag[h]  = h_acc[h][24] ? 24'(-h_acc[h]) : h_acc[h][23:0];
            hm_next[h] = 41'(h_mag[h]) * 41'(h_t[h]);
            h_rnd[h]  = hm_reg[h] + 41'd32768;
            h_val[h]  = hs_reg[h] ? -$signed(h_rnd[h][40:16]) : $signed(h_rnd[h][40:16]);
            ha_next[h] = h_val[h] + HCOEF[h];
        end

        // stage 30: scale by 2^-k
        ee30_next = (k_reg[29] >= 6'd31) ? 31'd0 : (te_reg[TAYLOR_N - 1] >> k_reg[29]);
        // stage 32: erfc/2 product
        poly      = ha_reg[HORNER_N - 1][24] ? 24'd0 : ha_reg[HORNER_N - 1][23:0];
        pe32_next = 55'(poly) * 55'(ee31_reg);
        // stage 33: round, clamp, fold by sign, saturate
        h_sum   = pe32_reg + 55'h4_0000_0000;
        h_clamp = (h_sum[54:35] > 20'h10000) ? 17'h10000 : h_sum[51:35];
        res     = neg_reg[NSTG - 1] ? h_clamp : (17'h10000 - h_clamp);
        out_next = res[16] ? 16'hFFFF : res[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-1:1], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_reg[1] <= s_tdata[15];
            for (int s = 2; s < NSTG; s++)
            begin
                neg_reg[s] <= neg_reg[s-1];
            end
            a1_reg  <= a1_next;
            z2_reg  <= z2_next;
            pz3_reg <= pz3_next;
            w3_reg  <= w3_next;
            d4_reg  <= d4_next;
            u4_reg  <= u4_next;
            g5_reg  <= g5_next;
            k_reg[5] <= u4_reg[21:16];
            for (int s = 6; s < 30; s++)
            begin
                k_reg[s] <= k_reg[s-1];
            end
            for (int j = 0; j < TAYLOR_N; j++)
            begin
                tp_reg[j]  <= tp_next[j];
                tga_reg[j] <= (j == 0) ? g5_reg : tgc_reg[(j == 0) ? 0 : j - 1];
                tq_reg[j]  <= tq_next[j];
                tpb_reg[j] <= tp_reg[j];
                tgb_reg[j] <= tga_reg[j];
                te_reg[j]  <= te_next[j];
                tgc_reg[j] <= tgb_reg[j];
            end
            for (int i = 0; i < DIV_N; i++)
            begin
                dr_reg[i] <= dr_next[i];
                dd_reg[i] <= dv_d[i];
                dq_reg[i] <= dq_next[i];
            end
            for (int h = 0; h < HORNER_N; h++)
            begin
                hm_reg[h]  <= hm_next[h];
                hs_reg[h]  <= h_acc[h][24];
                htm_reg[h] <= h_t[h];
                ha_reg[h]  <= ha_next[h];
                hta_reg[h] <= htm_reg[h];
            end
            ee30_reg <= ee30_next;
            ee31_reg <= ee30_reg;
            pe32_reg <= pe32_next;
            out_reg  <= out_next;
        end
    end

endmodule
